>>> design/srwc_pkg.sv
`default_nettype none

package srwc_pkg;

  // sequence and window geometry
  localparam int SEQ_BITS  = 6;
  localparam int WINDOW    = 32;
  localparam int SLOT_BITS = $clog2(WINDOW);
  localparam int CNT_BITS  = $clog2(WINDOW + 1);
  localparam int CMD_W     = 2;
  localparam int KIND_W    = 2;
  localparam int ACT_W     = 3;

  typedef logic [SEQ_BITS-1:0]  seq_t;
  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  // event codes on the input channel
  typedef enum logic [CMD_W-1:0] {
    CMD_PKT_READY  = 2'd0,
    CMD_LINK_READY = 2'd1,
    CMD_FRAME_RX   = 2'd2,
    CMD_TIMEOUT    = 2'd3
  } cmd_t;

  // received frame kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_DATA  = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_NAK   = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  // result commands
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD    = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_ACK     = 3'd2,
    ACT_NAK     = 3'd3,
    ACT_STORE   = 3'd4,
    ACT_DELIVER = 3'd5,
    ACT_STOP    = 3'd6,
    ACT_STATUS  = 3'd7
  } action_t;

  // sequence number source for an emitted command
  typedef enum logic [2:0] {
    SEL_NEXT_SEND,
    SEL_RX_PREV,
    SEL_IN_SEQ,
    SEL_IN_SEQ_NEXT,
    SEL_RX_EXP,
    SEL_OLDEST
  } seq_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     latch_in;
    logic     emit;
    action_t  act;
    seq_sel_t sel;
    logic     tx_inc;
    logic     tx_dec;
    logic     send_inc;
    logic     oldest_inc;
    logic     rx_adv;
    logic     mark_arrived;
    logic     link_set;
    logic     link_clr;
    logic     nak_clr;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic  out_free;
    cmd_t  cmd;
    kind_t kind;
    logic  good;
    logic  tx_room;
    logic  nak_allowed;
    logic  seq_unexpected;
    logic  data_new;
    logic  deliv_ready;
    logic  ack_more;
    logic  nak_resend;
    logic  timeout_hit;
  } dp_stat_t;

  // x in [lo, hi) on the circular sequence space
  function automatic logic in_range(seq_t lo, seq_t x, seq_t hi);
    return ((lo <= x) && (x < hi)) || ((hi < lo) && (lo <= x)) ||
           ((x < hi) && (hi < lo));
  endfunction

  // buffer slot: sequence modulo the window, a power of two
  function automatic slot_t slot_of(seq_t s);
    return s[SLOT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

>>> design/srwc_datapath.sv
`default_nettype none

module srwc_datapath
  import srwc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dp_cmd_t              dp_cmd,
  output      dp_stat_t             dp_stat,
  input  wire logic [CMD_W-1:0]     in_cmd,
  input  wire logic [KIND_W-1:0]    in_frame_kind,
  input  wire logic [SEQ_BITS-1:0]  in_seq_num,
  input  wire logic                 in_frame_good,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic [ACT_W-1:0]     out_action,
  output      logic [SEQ_BITS-1:0]  out_seq,
  output      logic [SLOT_BITS-1:0] out_slot,
  output      logic                 out_net_enable,
  output      logic                 out_last
);

  // latched input beat
  cmd_t  cmd_r;
  kind_t kind_r;
  seq_t  seq_r;
  logic  good_r;

  // window state
  seq_t              next_send_r;
  seq_t              oldest_r;
  seq_t              rx_exp_r;
  seq_t              rx_end_r;
  logic [WINDOW-1:0] arrived_r;
  cnt_t              tx_out_r;
  logic              nak_allowed_r;
  logic              link_r;

  // output register
  logic    out_valid_r;
  action_t out_action_r;
  seq_t    out_seq_r;
  slot_t   out_slot_r;
  logic    out_en_r;
  logic    out_last_r;

  seq_t sel_seq;
  seq_t rx_prev;
  seq_t seq_succ;
  logic out_free;
  logic tx_room;

  assign rx_prev  = seq_t'(rx_exp_r - 1'b1);
  assign seq_succ = seq_t'(seq_r + 1'b1);
  assign out_free = !out_valid_r || out_ready;
  assign tx_room  = tx_out_r < cnt_t'(WINDOW);

  // sequence number mux for the emitted command
  always_comb begin
    unique case (dp_cmd.sel)
      SEL_NEXT_SEND:   sel_seq = next_send_r;
      SEL_RX_PREV:     sel_seq = rx_prev;
      SEL_IN_SEQ:      sel_seq = seq_r;
      SEL_IN_SEQ_NEXT: sel_seq = seq_succ;
      SEL_RX_EXP:      sel_seq = rx_exp_r;
      SEL_OLDEST:      sel_seq = oldest_r;
      default:         sel_seq = '0;
    endcase
  end

  // status back to the controller
  always_comb begin
    dp_stat.out_free       = out_free;
    dp_stat.cmd            = cmd_r;
    dp_stat.kind           = kind_r;
    dp_stat.good           = good_r;
    dp_stat.tx_room        = tx_room;
    dp_stat.nak_allowed    = nak_allowed_r;
    dp_stat.seq_unexpected = seq_r != rx_exp_r;
    dp_stat.data_new       = in_range(rx_exp_r, seq_r, rx_end_r) &&
                             !arrived_r[slot_of(seq_r)];
    dp_stat.deliv_ready    = arrived_r[slot_of(rx_exp_r)];
    dp_stat.ack_more       = (tx_out_r != '0) && in_range(oldest_r, seq_r, next_send_r);
    dp_stat.nak_resend     = in_range(oldest_r, seq_succ, next_send_r);
    dp_stat.timeout_hit    = in_range(oldest_r, seq_r, next_send_r);
  end

  // input latch
  always_ff @(posedge clk) begin
    if (dp_cmd.latch_in) begin
      cmd_r  <= cmd_t'(in_cmd);
      kind_r <= kind_t'(in_frame_kind);
      seq_r  <= in_seq_num;
      good_r <= in_frame_good;
    end
  end

  // transmit window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_send_r <= '0;
      oldest_r    <= '0;
      tx_out_r    <= '0;
    end else begin
      if (dp_cmd.send_inc) next_send_r <= seq_t'(next_send_r + 1'b1);
      if (dp_cmd.oldest_inc) oldest_r <= seq_t'(oldest_r + 1'b1);
      if (dp_cmd.tx_inc) begin
        tx_out_r <= cnt_t'(tx_out_r + 1'b1);
      end else if (dp_cmd.tx_dec) begin
        tx_out_r <= cnt_t'(tx_out_r - 1'b1);
      end
    end
  end

  // receive window and arrived map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_exp_r  <= '0;
      rx_end_r  <= seq_t'(WINDOW);
      arrived_r <= '0;
    end else begin
      if (dp_cmd.mark_arrived) arrived_r[slot_of(seq_r)] <= 1'b1;
      if (dp_cmd.rx_adv) begin
        arrived_r[slot_of(rx_exp_r)] <= 1'b0;
        rx_exp_r <= seq_t'(rx_exp_r + 1'b1);
        rx_end_r <= seq_t'(rx_end_r + 1'b1);
      end
    end
  end

  // nak and link flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nak_allowed_r <= 1'b1;
      link_r        <= 1'b0;
    end else begin
      if (dp_cmd.rx_adv) begin
        nak_allowed_r <= 1'b1;
      end else if (dp_cmd.nak_clr) begin
        nak_allowed_r <= 1'b0;
      end
      if (dp_cmd.link_set) begin
        link_r <= 1'b1;
      end else if (dp_cmd.link_clr) begin
        link_r <= 1'b0;
      end
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dp_cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (dp_cmd.emit) begin
      out_action_r <= dp_cmd.act;
      if (dp_cmd.act == ACT_STATUS) begin
        out_seq_r  <= '0;
        out_slot_r <= '0;
        out_en_r   <= tx_room && link_r;
        out_last_r <= 1'b1;
      end else begin
        out_seq_r  <= sel_seq;
        out_slot_r <= slot_of(sel_seq);
        out_en_r   <= 1'b0;
        out_last_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_action     = out_action_r;
  assign out_seq        = out_seq_r;
  assign out_slot       = out_slot_r;
  assign out_net_enable = out_en_r;
  assign out_last       = out_last_r;

  // checks
  assert property (@(posedge clk) disable iff (!rst_n)
    tx_out_r <= cnt_t'(WINDOW))
    else $error("outstanding count above window");

  assert property (@(posedge clk) disable iff (!rst_n)
    seq_t'(rx_end_r - rx_exp_r) == seq_t'(WINDOW))
    else $error("receive window span lost");

  assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.emit |-> out_free)
    else $error("command emitted into a full output register");

  assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.rx_adv |-> arrived_r[slot_of(rx_exp_r)])
    else $error("delivery of a slot that has not arrived");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_action_r == ACT_STATUS))
    else $error("last beat is not a status");

endmodule

`default_nettype wire

>>> design/srwc_ctrl.sv
`default_nettype none

module srwc_ctrl
  import srwc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output      logic     in_ready,
  input  wire dp_stat_t dp_stat,
  output      dp_cmd_t  dp_cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_LOAD,
    S_SEND_NEW,
    S_NAK_BAD,
    S_DATA_NAK,
    S_DATA_CHK,
    S_STORE,
    S_DELIVER,
    S_ACK_OUT,
    S_NAK_RX,
    S_ACK_LOOP,
    S_TIMEOUT,
    S_STATUS
  } state_t;

  state_t state_r, state_nxt;
  logic   any_r, any_nxt;

  assign in_ready = state_r == S_IDLE;

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    any_nxt   = any_r;
    dp_cmd    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.latch_in = 1'b1;
          state_nxt       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (dp_stat.cmd)
          CMD_PKT_READY: state_nxt = dp_stat.tx_room ? S_LOAD : S_STATUS;
          CMD_LINK_READY: begin
            dp_cmd.link_set = 1'b1;
            state_nxt       = S_STATUS;
          end
          CMD_FRAME_RX: begin
            if (!dp_stat.good) begin
              state_nxt = dp_stat.nak_allowed ? S_NAK_BAD : S_STATUS;
            end else begin
              unique case (dp_stat.kind)
                KIND_DATA: state_nxt = S_DATA_NAK;
                KIND_ACK:  state_nxt = S_ACK_LOOP;
                KIND_NAK:  state_nxt = S_NAK_RX;
                default:   state_nxt = S_STATUS;
              endcase
            end
          end
          default: state_nxt = S_TIMEOUT;
        endcase
      end
      S_LOAD: begin
        if (dp_stat.out_free) begin
          dp_cmd.emit   = 1'b1;
          dp_cmd.act    = ACT_LOAD;
          dp_cmd.sel    = SEL_NEXT_SEND;
          dp_cmd.tx_inc = 1'b1;
          state_nxt     = S_SEND_NEW;
        end
      end
      S_SEND_NEW: begin
        if (dp_stat.out_free) begin
          dp_cmd.emit     = 1'b1;
          dp_cmd.act      = ACT_SEND;
          dp_cmd.sel      = SEL_NEXT_SEND;
          dp_cmd.link_clr = 1'b1;
          dp_cmd.send_inc = 1'b1;
          state_nxt       = S_STATUS;
        end
      end
      S_NAK_BAD: begin
        if (dp_stat.out_free) begin
          dp_cmd.emit     = 1'b1;
          dp_cmd.act      = ACT_NAK;
          dp_cmd.sel      = SEL_RX_PREV;
          dp_cmd.nak_clr  = 1'b1;
          dp_cmd.link_clr = 1'b1;
          state_nxt       = S_STATUS;
        end
      end
      // out-of-order data asks once for the missing frame
      S_DATA_NAK: begin
        if (dp_stat.seq_unexpected && dp_stat.nak_allowed) begin
          if (dp_stat.out_free) begin
            dp_cmd.emit     = 1'b1;
            dp_cmd.act      = ACT_NAK;
            dp_cmd.sel      = SEL_RX_PREV;
            dp_cmd.nak_clr  = 1'b1;
            dp_cmd.link_clr = 1'b1;
            state_nxt       = S_DATA_CHK;
          end
        end else begin
          state_nxt = S_DATA_CHK;
        end
      end
      S_DATA_CHK: begin
        any_nxt   = 1'b0;
        state_nxt = dp_stat.data_new ? S_STORE : S_STATUS;
      end
      S_STORE: begin
        if (dp_stat.out_free) begin
          dp_cmd.emit         = 1'b1;
          dp_cmd.act          = ACT_STORE;
          dp_cmd.sel          = SEL_IN_SEQ;
          dp_cmd.mark_arrived = 1'b1;
          state_nxt           = S_DELIVER;
        end
      end
      // hand up the in-order run, one slot a beat
      S_DELIVER: begin
        if (dp_stat.deliv_ready) begin
          if (dp_stat.out_free) begin
            dp_cmd.emit   = 1'b1;
            dp_cmd.act    = ACT_DELIVER;
            dp_cmd.sel    = SEL_RX_EXP;
            dp_cmd.rx_adv = 1'b1;
            any_nxt       = 1'b1;
          end
        end else begin
          state_nxt = any_r ? S_ACK_OUT : S_STATUS;
        end
      end
      S_ACK_OUT: begin
        if (dp_stat.out_free) begin
          dp_cmd.emit     = 1'b1;
          dp_cmd.act      = ACT_ACK;
          dp_cmd.sel      = SEL_RX_PREV;
          dp_cmd.link_clr = 1'b1;
          state_nxt       = S_STATUS;
        end
      end
      // a nak resends the frame after it, then acts as an ack
      S_NAK_RX: begin
        if (dp_stat.nak_resend) begin
          if (dp_stat.out_free) begin
            dp_cmd.emit     = 1'b1;
            dp_cmd.act      = ACT_SEND;
            dp_cmd.sel      = SEL_IN_SEQ_NEXT;
            dp_cmd.link_clr = 1'b1;
            state_nxt       = S_ACK_LOOP;
          end
        end else begin
          state_nxt = S_ACK_LOOP;
        end
      end
      // cumulative ack retires frames from the oldest on
      S_ACK_LOOP: begin
        if (dp_stat.ack_more) begin
          if (dp_stat.out_free) begin
            dp_cmd.emit       = 1'b1;
            dp_cmd.act        = ACT_STOP;
            dp_cmd.sel        = SEL_OLDEST;
            dp_cmd.tx_dec     = 1'b1;
            dp_cmd.oldest_inc = 1'b1;
          end
        end else begin
          state_nxt = S_STATUS;
        end
      end
      S_TIMEOUT: begin
        if (dp_stat.timeout_hit) begin
          if (dp_stat.out_free) begin
            dp_cmd.emit     = 1'b1;
            dp_cmd.act      = ACT_SEND;
            dp_cmd.sel      = SEL_IN_SEQ;
            dp_cmd.link_clr = 1'b1;
            state_nxt       = S_STATUS;
          end
        end else begin
          state_nxt = S_STATUS;
        end
      end
      S_STATUS: begin
        if (dp_stat.out_free) begin
          dp_cmd.emit = 1'b1;
          dp_cmd.act  = ACT_STATUS;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      any_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      any_r   <= any_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/selective_repeat_window_control_core.sv
// flow: an accepted input beat is latched, decoded in a decision step, and answered by its result
//   commands and then a status beat; each beat is held in the output register
// throughput: the controller emits at most one result beat a cycle, while out_ready allows, into a
//   single output register and takes the next item only after the status beat
// reset: rst_n synchronous active low; windows empty, nak allowed, link not ready
`default_nettype none

module selective_repeat_window_control_core
  import srwc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [CMD_W-1:0]     in_cmd,
  input  wire logic [KIND_W-1:0]    in_frame_kind,
  input  wire logic [SEQ_BITS-1:0]  in_seq_num,
  input  wire logic                 in_frame_good,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic [ACT_W-1:0]     out_action,
  output      logic [SEQ_BITS-1:0]  out_seq,
  output      logic [SLOT_BITS-1:0] out_slot,
  output      logic                 out_net_enable,
  output      logic                 out_last
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // event sequencer
  srwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .dp_stat  (dp_stat),
    .dp_cmd   (dp_cmd)
  );

  // window state and result register
  srwc_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .dp_cmd         (dp_cmd),
    .dp_stat        (dp_stat),
    .in_cmd         (in_cmd),
    .in_frame_kind  (in_frame_kind),
    .in_seq_num     (in_seq_num),
    .in_frame_good  (in_frame_good),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_action     (out_action),
    .out_seq        (out_seq),
    .out_slot       (out_slot),
    .out_net_enable (out_net_enable),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire
